// File: rtl/rbi_pkg.sv
// Package for the register bytecode interpreter.
// Holds command, opcode and status codes, default sizes and the shared adder request type.
// No dependencies.
package rbi_pkg;

  // Default store sizes
  localparam int PROG_DEPTH_DEF = 64;
  localparam int NUM_REGS_DEF   = 5;
  localparam int ARG_COUNT_DEF  = 8;

  // Field widths
  localparam int CMD_W    = 2;
  localparam int ADDR_W   = 6;
  localparam int OPCODE_W = 3;
  localparam int WORD_W   = 32;
  localparam int STATUS_W = 2;
  localparam int LIMIT_W  = 21;
  localparam int ALU_W    = 34;

  localparam logic [LIMIT_W-1:0] STEP_LIMIT_RST = 21'd65536;

  // Commands
  localparam logic [CMD_W-1:0] CMD_PROG = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ARG  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RUN  = 2'd2;

  // Opcodes
  localparam logic [OPCODE_W-1:0] OP_IMM = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_ARG = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_MOV = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_ADD = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_SUB = 3'd4;
  localparam logic [OPCODE_W-1:0] OP_JMP = 3'd5;
  localparam logic [OPCODE_W-1:0] OP_JZE = 3'd6;
  localparam logic [OPCODE_W-1:0] OP_RET = 3'd7;

  // Run status
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_PC    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_IDX   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_LIMIT = 2'd3;

  // Request to the shared adder: x plus or minus y
  typedef struct packed {
    logic [ALU_W-1:0] x;
    logic [ALU_W-1:0] y;
    logic             sub;
  } alu_req_t;

endpackage

// File: rtl/rbi_alu.sv
// Shared 34-bit add/subtract unit of the interpreter.
// Serves register add and subtract and relative jump targets; uses rbi_pkg.
module rbi_alu (
  input  rbi_pkg::alu_req_t           req,
  output logic [rbi_pkg::ALU_W-1:0]   sum
);

  logic [rbi_pkg::ALU_W-1:0] y_op;

  // Invert and carry in for subtract
  assign y_op = req.sub ? ~req.y : req.y;
  assign sum  = req.x + y_op + rbi_pkg::ALU_W'(req.sub);

endmodule

// File: rtl/rbi_regfile.sv
// Register file of the interpreter: one write port, two registered read ports.
// Entries read as zero until first written; uses rbi_pkg for the word width.
module rbi_regfile #(
  parameter int NUM_REGS = rbi_pkg::NUM_REGS_DEF,
  localparam int RW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       rd_en,
  input  logic [RW-1:0]              rd_a_idx,
  input  logic [RW-1:0]              rd_b_idx,
  output logic [rbi_pkg::WORD_W-1:0] rd_a_data,
  output logic [rbi_pkg::WORD_W-1:0] rd_b_data,
  input  logic                       wr_en,
  input  logic [RW-1:0]              wr_idx,
  input  logic [rbi_pkg::WORD_W-1:0] wr_data
);

  logic [rbi_pkg::WORD_W-1:0] mem [NUM_REGS];
  logic [NUM_REGS-1:0]        valid;

  // Mark entries written since reset
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr_en && (32'(wr_idx) < 32'(NUM_REGS))) begin
      valid[wr_idx] <= 1'b1;
    end
  end

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en && (32'(wr_idx) < 32'(NUM_REGS))) begin
      mem[wr_idx] <= wr_data;
    end
  end

  // Registered read ports; an unwritten entry reads as zero
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_a_data <= ((32'(rd_a_idx) < 32'(NUM_REGS)) && valid[rd_a_idx]) ? mem[rd_a_idx] : '0;
      rd_b_data <= ((32'(rd_b_idx) < 32'(NUM_REGS)) && valid[rd_b_idx]) ? mem[rd_b_idx] : '0;
    end
  end

endmodule

// File: rtl/register_bytecode_interpreter.sv
// Register bytecode interpreter: a load beat writes a program word or an argument. A run
// executes its instructions one at a time, each passing through a program store read, a
// register file read and an execute step that uses the shared adder for add, subtract and
// jumps. A run stops when it halts, on a bad register or argument index, on the step limit
// or on a bad PC. The registered reads of the program store and the register file set the
// pace of a run. No new beat is taken while a run is in progress. Registers read as zero
// after reset; program and argument stores hold no defined value until written.
// Depends on rbi_pkg, rbi_alu and rbi_regfile.
module register_bytecode_interpreter #(
  parameter int PROG_DEPTH = rbi_pkg::PROG_DEPTH_DEF,
  parameter int NUM_REGS   = rbi_pkg::NUM_REGS_DEF,
  parameter int ARG_COUNT  = rbi_pkg::ARG_COUNT_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration
  input  logic                                cfg_wr_en,
  input  logic [rbi_pkg::LIMIT_W-1:0]         cfg_wr_data,
  // input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [rbi_pkg::CMD_W-1:0]           cmd,
  input  logic [rbi_pkg::ADDR_W-1:0]          addr,
  input  logic [rbi_pkg::OPCODE_W-1:0]        opcode,
  input  logic signed [rbi_pkg::WORD_W-1:0]   operand_a,
  input  logic signed [rbi_pkg::WORD_W-1:0]   operand_b,
  input  logic signed [rbi_pkg::WORD_W-1:0]   arg_value,
  // output channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [rbi_pkg::WORD_W-1:0]   result_value,
  output logic [rbi_pkg::STATUS_W-1:0]        status
);

  localparam int PW  = $clog2(PROG_DEPTH);
  localparam int PW1 = PW + 1;
  localparam int RW  = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
  localparam int AW  = (ARG_COUNT > 1) ? $clog2(ARG_COUNT) : 1;
  localparam int WW  = rbi_pkg::WORD_W;
  localparam int XW  = rbi_pkg::ALU_W;

  // Sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_FETCH = 3'd2;
  localparam logic [2:0] S_EXEC  = 3'd3;
  localparam logic [2:0] S_POST  = 3'd4;

  logic [2:0]                    state;
  logic [PW-1:0]                 pc;
  logic                          pc_bad;
  logic [rbi_pkg::LIMIT_W-1:0]   step_count;
  logic [rbi_pkg::LIMIT_W-1:0]   step_limit;
  logic [WW-1:0]                 res_value;
  logic [rbi_pkg::STATUS_W-1:0]  res_status;

  // Program and argument stores
  logic [rbi_pkg::OPCODE_W+WW-1:0] prog_op_a [PROG_DEPTH];
  logic [WW-1:0]                   prog_b    [PROG_DEPTH];
  logic [WW-1:0]                   arg_mem   [ARG_COUNT];
  logic [rbi_pkg::OPCODE_W-1:0]    ins_op;
  logic [WW-1:0]                   ins_a;
  logic [WW-1:0]                   ins_b;
  logic [WW-1:0]                   arg_rd;

  logic in_beat;
  logic out_free;

  assign in_stall = (state != S_IDLE);
  assign in_beat  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // Step limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      step_limit <= rbi_pkg::STEP_LIMIT_RST;
    end else if (cfg_wr_en) begin
      step_limit <= cfg_wr_data;
    end
  end

  // Program store: write on a load beat, read at pc when issuing an instruction
  always_ff @(posedge clk) begin
    if (in_beat && (cmd == rbi_pkg::CMD_PROG) && (32'(addr) < 32'(PROG_DEPTH))) begin
      prog_op_a[PW'(addr)] <= {opcode, operand_a};
      prog_b[PW'(addr)]    <= operand_b;
    end
    if (state == S_CHECK) begin
      {ins_op, ins_a} <= prog_op_a[pc];
      ins_b           <= prog_b[pc];
    end
  end

  // Argument store: write on a load beat, read at operand b during register read
  always_ff @(posedge clk) begin
    if (in_beat && (cmd == rbi_pkg::CMD_ARG) && (32'(addr) < 32'(ARG_COUNT))) begin
      arg_mem[AW'(addr)] <= arg_value;
    end
    if ((state == S_FETCH) && (ins_b < 32'(ARG_COUNT))) begin
      arg_rd <= arg_mem[AW'(ins_b)];
    end
  end

  // Register file
  logic          rf_wr_en;
  logic [WW-1:0] rf_wr_data;
  logic [WW-1:0] rda;
  logic [WW-1:0] rdb;

  rbi_regfile #(
    .NUM_REGS (NUM_REGS)
  ) u_regfile (
    .clk       (clk),
    .rst       (rst),
    .rd_en     (state == S_FETCH),
    .rd_a_idx  (RW'(ins_a)),
    .rd_b_idx  (RW'(ins_b)),
    .rd_a_data (rda),
    .rd_b_data (rdb),
    .wr_en     (rf_wr_en),
    .wr_idx    (RW'(ins_a)),
    .wr_data   (rf_wr_data)
  );

  // Shared adder
  rbi_pkg::alu_req_t alu_req;
  logic [XW-1:0]     alu_sum;

  rbi_alu u_alu (
    .req (alu_req),
    .sum (alu_sum)
  );

  // Decode the fetched instruction
  logic a_ok;
  logic b_reg_ok;
  logic b_arg_ok;
  logic idx_err;
  logic is_jump;
  logic is_halt;
  logic writes_reg;

  assign a_ok     = (ins_a < 32'(NUM_REGS));
  assign b_reg_ok = (ins_b < 32'(NUM_REGS));
  assign b_arg_ok = (ins_b < 32'(ARG_COUNT));

  always_comb begin
    idx_err    = 1'b0;
    is_jump    = 1'b0;
    is_halt    = 1'b0;
    writes_reg = 1'b0;
    rf_wr_data = ins_b;
    alu_req.x   = {{(XW-WW){rda[WW-1]}}, rda};
    alu_req.y   = {{(XW-WW){rdb[WW-1]}}, rdb};
    alu_req.sub = (ins_op == rbi_pkg::OP_SUB);
    unique case (ins_op) inside
      rbi_pkg::OP_IMM: begin
        idx_err    = !a_ok;
        writes_reg = 1'b1;
        rf_wr_data = ins_b;
      end
      rbi_pkg::OP_ARG: begin
        idx_err    = !a_ok || !b_arg_ok;
        writes_reg = 1'b1;
        rf_wr_data = arg_rd;
      end
      rbi_pkg::OP_MOV: begin
        idx_err    = !a_ok || !b_reg_ok;
        writes_reg = 1'b1;
        rf_wr_data = rdb;
      end
      rbi_pkg::OP_ADD, rbi_pkg::OP_SUB: begin
        idx_err    = !a_ok || !b_reg_ok;
        writes_reg = 1'b1;
        rf_wr_data = alu_sum[WW-1:0];
      end
      rbi_pkg::OP_JMP: begin
        // Jump by operand a; a jump by zero halts on register zero
        alu_req.x = XW'(pc);
        alu_req.y = {{(XW-WW){ins_a[WW-1]}}, ins_a};
        is_halt   = (ins_a == '0);
        is_jump   = !is_halt;
      end
      rbi_pkg::OP_JZE: begin
        // Jump by operand b when the tested register is zero; a jump by zero halts
        idx_err   = !a_ok;
        alu_req.x = XW'(pc);
        alu_req.y = {{(XW-WW){ins_b[WW-1]}}, ins_b};
        is_halt   = (rda == '0) && (ins_b == '0);
        is_jump   = (rda == '0) && (ins_b != '0);
      end
      rbi_pkg::OP_RET: begin
        idx_err = !a_ok;
        is_halt = 1'b1;
      end
      default: begin
        idx_err = 1'b1;
      end
    endcase
  end

  assign rf_wr_en = (state == S_EXEC) && writes_reg && !idx_err;

  // Next pc for a jump and for a plain step
  logic [PW1-1:0] pc_inc;
  logic           jump_bad;

  assign pc_inc   = {1'b0, pc} + PW1'(1);
  assign jump_bad = alu_sum[XW-1] || (alu_sum[XW-2:0] >= (XW-1)'(PROG_DEPTH));

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      pc         <= '0;
      pc_bad     <= 1'b0;
      step_count <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_beat && (cmd == rbi_pkg::CMD_RUN)) begin
            pc         <= '0;
            pc_bad     <= 1'b0;
            step_count <= '0;
            state      <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (step_count >= step_limit) begin
            state <= S_POST;
          end else if (pc_bad) begin
            state <= S_POST;
          end else begin
            step_count <= step_count + rbi_pkg::LIMIT_W'(1);
            state      <= S_FETCH;
          end
        end
        S_FETCH: begin
          state <= S_EXEC;
        end
        S_EXEC: begin
          if (idx_err || is_halt) begin
            state <= S_POST;
          end else if (is_jump) begin
            pc     <= alu_sum[PW-1:0];
            pc_bad <= jump_bad;
            state  <= S_CHECK;
          end else begin
            pc     <= pc_inc[PW-1:0];
            pc_bad <= (pc_inc == PW1'(PROG_DEPTH));
            state  <= S_CHECK;
          end
        end
        S_POST: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Capture the outcome of the run
  always_ff @(posedge clk) begin
    if (state == S_CHECK) begin
      res_value  <= '0;
      res_status <= (step_count >= step_limit) ? rbi_pkg::ST_LIMIT : rbi_pkg::ST_PC;
    end else if (state == S_EXEC) begin
      res_value  <= idx_err ? '0 : rda;
      res_status <= idx_err ? rbi_pkg::ST_IDX : rbi_pkg::ST_OK;
    end
  end

  // Output register: load the result beat, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_POST) && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_POST) && out_free) begin
      result_value <= res_value;
      status       <= res_status;
    end
  end

endmodule

// File: rtl/rbi_checker.sv
// Port-level checks for the register bytecode interpreter, bound to the top level.
// Uses rbi_pkg for command and status codes.
module rbi_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic [rbi_pkg::CMD_W-1:0]    cmd,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [rbi_pkg::WORD_W-1:0]   result_value,
  input logic [rbi_pkg::STATUS_W-1:0] status
);

  // Hold a stalled result beat
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(result_value) && $stable(status))
    else $error("stalled result beat changed");

  // Error results carry zero
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != rbi_pkg::ST_OK) |-> (result_value == '0))
    else $error("error result with nonzero value");

  // Stall the input while a run is in progress
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (cmd == rbi_pkg::CMD_RUN) |=> in_stall)
    else $error("input taken during a run");

  // A load beat raises no result
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (cmd != rbi_pkg::CMD_RUN) && !out_valid |=> !out_valid)
    else $error("result beat after a load");

endmodule

bind register_bytecode_interpreter rbi_checker u_rbi_checker (.*);
